### rtl/lnr_pkg.sv
// shared types and constants for the layer norm row unit
package lnr_pkg;

  // count width for row length and fill level
  localparam int CNT_W = 7;

  // configuration register indexes
  localparam logic [1:0] REG_ROW_LENGTH = 2'd0;
  localparam logic [1:0] REG_GAIN       = 2'd1;
  localparam logic [1:0] REG_EPSILON    = 2'd2;

  // reset values of the configuration registers
  localparam logic [6:0]         ROW_LENGTH_RST = 7'd64;
  localparam logic signed [15:0] GAIN_RST       = 16'sd4096;
  localparam logic [15:0]        EPSILON_RST    = 16'd168;

  // shared divider geometry
  localparam int QW = 63;
  localparam int VW = 33;
  localparam int SW = 6;

  // divider step counts for each job
  localparam logic [SW-1:0] MEAN_STEPS = 6'd22;
  localparam logic [SW-1:0] VAR_STEPS  = 6'd38;
  localparam logic [SW-1:0] RCP_STEPS  = 6'd63;

  // which job the shared divider runs
  typedef enum logic [1:0] {
    SEL_MEAN,
    SEL_VAR,
    SEL_RCP
  } div_sel_t;

  // controller states
  typedef enum logic [3:0] {
    S_IDLE,
    S_MEAN_GO,
    S_MEAN_WAIT,
    S_VAR_RD,
    S_VAR_DRAIN,
    S_VDIV_GO,
    S_VDIV_WAIT,
    S_RCP_GO,
    S_RCP_WAIT,
    S_SQRT_GO,
    S_SQRT_WAIT,
    S_OUT_RD,
    S_OUT_DRAIN
  } state_t;

  // controller to datapath commands
  typedef struct packed {
    logic             load;
    logic             acc_clr;
    logic             row_clr;
    logic             div_go;
    div_sel_t         div_sel;
    logic             sqrt_go;
    logic             rd_en;
    logic             rd_last;
    logic             out_pass;
    logic [CNT_W-1:0] rd_idx;
  } cmd_t;

  // datapath to controller status
  typedef struct packed {
    logic             row_full;
    logic             div_done;
    logic             sqrt_done;
    logic             pipe_busy;
    logic [CNT_W-1:0] n;
  } sts_t;

endpackage

### rtl/lnr_ram.sv
// generic single port write, registered read ram
module lnr_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 64,
  parameter int AW    = 6
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write port and registered read
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

### rtl/lnr_div.sv
// restoring divider, one quotient bit per cycle
module lnr_div (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  go,
  input  logic [lnr_pkg::QW-1:0] dividend,
  input  logic [lnr_pkg::VW-1:0] divisor,
  input  logic [lnr_pkg::SW-1:0] steps,
  output logic                  done,
  output logic [lnr_pkg::QW-1:0] quotient
);

  logic                   run;
  logic [lnr_pkg::SW-1:0] cnt;
  logic [lnr_pkg::VW-1:0] rem;
  logic [lnr_pkg::VW-1:0] dv;
  logic [lnr_pkg::QW-1:0] quo;
  logic [lnr_pkg::VW:0]   trial;
  logic [lnr_pkg::VW:0]   diff;
  logic                   ge;

  // one shift and subtract step
  always_comb begin
    trial = {rem, quo[lnr_pkg::QW-1]};
    diff  = trial - {1'b0, dv};
    ge    = trial >= {1'b0, dv};
  end

  // control
  always_ff @(posedge clk) begin
    if (rst) begin
      run  <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (go) begin
        run <= 1'b1;
        cnt <= steps;
      end else if (run) begin
        cnt <= cnt - 1'b1;
        if (cnt == 1) begin
          run  <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  // remainder and quotient
  always_ff @(posedge clk) begin
    if (go) begin
      rem <= '0;
      dv  <= divisor;
      quo <= dividend;
    end else if (run) begin
      rem <= ge ? diff[lnr_pkg::VW-1:0] : trial[lnr_pkg::VW-1:0];
      quo <= {quo[lnr_pkg::QW-2:0], ge};
    end
  end

  assign quotient = quo;

endmodule

### rtl/lnr_isqrt.sv
// integer square root, two radicand bits per cycle
module lnr_isqrt (
  input  logic        clk,
  input  logic        rst,
  input  logic        go,
  input  logic [62:0] radicand,
  output logic        done,
  output logic [31:0] root
);

  logic        run;
  logic [63:0] rad;
  logic [63:0] res;
  logic [63:0] bt;
  logic [63:0] trial;

  assign trial = res + bt;

  // control
  always_ff @(posedge clk) begin
    if (rst) begin
      run  <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (go) begin
        run <= 1'b1;
      end else if (run && bt[0]) begin
        run  <= 1'b0;
        done <= 1'b1;
      end
    end
  end

  // digit recurrence
  always_ff @(posedge clk) begin
    if (go) begin
      rad <= {1'b0, radicand};
      res <= '0;
      bt  <= 64'h4000_0000_0000_0000;
    end else if (run) begin
      if (rad >= trial) begin
        rad <= rad - trial;
        res <= (res >> 1) + bt;
      end else begin
        res <= res >> 1;
      end
      bt <= bt >> 2;
    end
  end

  assign root = res[31:0];

endmodule

### rtl/lnr_dp.sv
// datapath: config, row store, statistics, scaling pipeline
module lnr_dp #(
  parameter int MAX_ROW = 64,
  parameter int AW      = 6
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                wr_en,
  input  logic [1:0]          wr_index,
  input  logic [15:0]         wr_data,
  input  logic signed [15:0]  sample,
  input  lnr_pkg::cmd_t       cmd,
  output lnr_pkg::sts_t       sts,
  output logic signed [23:0]  normalized,
  output logic                row_end,
  output logic                strobe
);

  localparam logic [lnr_pkg::CNT_W-1:0] MAX_N = lnr_pkg::CNT_W'(MAX_ROW);

  logic [6:0]         row_length;
  logic signed [15:0] gain;
  logic [15:0]        epsilon;
  logic [6:0]         len_eff;

  logic [lnr_pkg::CNT_W-1:0] fill;
  logic signed [21:0]        sum;
  logic [37:0]               acc;
  logic signed [16:0]        mean;
  logic [32:0]               vsum;
  logic [62:0]               rcp_sq;
  logic [31:0]               rcp;

  logic [15:0] rdata;

  logic                   div_done;
  logic [lnr_pkg::QW-1:0] div_q;
  logic [lnr_pkg::QW-1:0] div_a;
  logic [lnr_pkg::VW-1:0] div_b;
  logic [lnr_pkg::SW-1:0] div_steps;
  logic [21:0]            sum_mag;
  logic [32:0]            vtmp;
  logic                   sqrt_done;
  logic [31:0]            root;

  logic               s0_v, s0_last;
  logic               s1_v, s1_last;
  logic signed [16:0] d;
  logic               s2_v, s2_last;
  logic signed [33:0] m_res;
  logic signed [16:0] m_a;
  logic               s3_v, s3_last, s3_neg;
  logic [63:0]        prod;
  logic [33:0]        mag34;
  logic [31:0]        mag;
  logic [17:0]        d_wide;
  logic [63:0]        rnd;
  logic [32:0]        mag_r;

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      row_length <= lnr_pkg::ROW_LENGTH_RST;
      gain       <= lnr_pkg::GAIN_RST;
      epsilon    <= lnr_pkg::EPSILON_RST;
    end else if (wr_en) begin
      case (wr_index)
        lnr_pkg::REG_ROW_LENGTH: row_length <= wr_data[6:0];
        lnr_pkg::REG_GAIN:       gain       <= signed'(wr_data);
        lnr_pkg::REG_EPSILON:    epsilon    <= wr_data;
        default: ;
      endcase
    end
  end

  // effective row length
  always_comb begin
    if (row_length == '0) begin
      len_eff = 7'd1;
    end else if (row_length > MAX_N) begin
      len_eff = MAX_N;
    end else begin
      len_eff = row_length;
    end
  end

  // fill level and running sum
  always_ff @(posedge clk) begin
    if (rst) begin
      fill <= '0;
      sum  <= '0;
    end else if (cmd.row_clr) begin
      fill <= '0;
      sum  <= '0;
    end else if (cmd.load) begin
      fill <= fill + 1'b1;
      sum  <= sum + 22'(sample);
    end
  end

  assign sts.row_full  = (fill + 1'b1) >= len_eff;
  assign sts.n         = fill;
  assign sts.div_done  = div_done;
  assign sts.sqrt_done = sqrt_done;
  assign sts.pipe_busy = s0_v | s1_v | s2_v | s3_v;

  // row store
  lnr_ram #(.WIDTH(16), .DEPTH(MAX_ROW), .AW(AW)) u_store (
    .clk   (clk),
    .we    (cmd.load),
    .waddr (fill[AW-1:0]),
    .wdata (sample),
    .re    (cmd.rd_en),
    .raddr (cmd.rd_idx[AW-1:0]),
    .rdata (rdata)
  );

  // divider operand select
  always_comb begin
    sum_mag = sum[21] ? 22'(-sum) : 22'(sum);
    case (cmd.div_sel)
      lnr_pkg::SEL_MEAN: begin
        div_a     = {sum_mag, 41'd0};
        div_b     = lnr_pkg::VW'(fill);
        div_steps = lnr_pkg::MEAN_STEPS;
      end
      lnr_pkg::SEL_VAR: begin
        div_a     = {acc, 25'd0};
        div_b     = lnr_pkg::VW'(fill);
        div_steps = lnr_pkg::VAR_STEPS;
      end
      lnr_pkg::SEL_RCP: begin
        div_a     = {1'b1, 62'd0};
        div_b     = vsum;
        div_steps = lnr_pkg::RCP_STEPS;
      end
      default: begin
        div_a     = '0;
        div_b     = vsum;
        div_steps = lnr_pkg::RCP_STEPS;
      end
    endcase
    vtmp = {1'b0, div_q[31:0]} + 33'(epsilon);
  end

  lnr_div u_div (
    .clk      (clk),
    .rst      (rst),
    .go       (cmd.div_go),
    .dividend (div_a),
    .divisor  (div_b),
    .steps    (div_steps),
    .done     (div_done),
    .quotient (div_q)
  );

  lnr_isqrt u_isqrt (
    .clk      (clk),
    .rst      (rst),
    .go       (cmd.sqrt_go),
    .radicand (rcp_sq),
    .done     (sqrt_done),
    .root     (root)
  );

  // statistics captured from the shared units
  always_ff @(posedge clk) begin
    if (div_done) begin
      case (cmd.div_sel)
        lnr_pkg::SEL_MEAN: mean   <= sum[21] ? -signed'(div_q[16:0]) : signed'(div_q[16:0]);
        lnr_pkg::SEL_VAR:  vsum   <= (vtmp == '0) ? 33'd1 : vtmp;
        lnr_pkg::SEL_RCP:  rcp_sq <= div_q;
        default: ;
      endcase
    end
    if (sqrt_done) begin
      rcp <= root;
    end
  end

  // pipeline valid tags
  always_ff @(posedge clk) begin
    if (rst) begin
      s0_v   <= 1'b0;
      s1_v   <= 1'b0;
      s2_v   <= 1'b0;
      s3_v   <= 1'b0;
      strobe <= 1'b0;
      row_end <= 1'b0;
    end else begin
      s0_v    <= cmd.rd_en;
      s1_v    <= s0_v;
      s2_v    <= s1_v;
      s3_v    <= s2_v & cmd.out_pass;
      strobe  <= s3_v;
      row_end <= s3_v & s3_last;
    end
  end

  // centered sample, shared multiplier, product
  always_comb begin
    d_wide = {{2{rdata[15]}}, rdata} - {mean[16], mean};
    m_a    = cmd.out_pass ? 17'(gain) : d;
    mag34  = m_res[33] ? 34'(-m_res) : 34'(m_res);
    mag    = mag34[31:0];
    rnd    = prod + 64'h4000_0000;
    mag_r  = rnd[63:31];
  end

  always_ff @(posedge clk) begin
    s0_last <= cmd.rd_last;
    s1_last <= s0_last;
    d       <= signed'(d_wide[16:0]);
    s2_last <= s1_last;
    m_res   <= m_a * d;
    s3_last <= s2_last;
    s3_neg  <= m_res[33];
    prod    <= mag * rcp;
  end

  // sum of squares
  always_ff @(posedge clk) begin
    if (cmd.acc_clr) begin
      acc <= '0;
    end else if (s2_v && !cmd.out_pass) begin
      acc <= acc + 38'(unsigned'(m_res));
    end
  end

  // rounding and saturation
  always_ff @(posedge clk) begin
    if (s3_v) begin
      if (s3_neg) begin
        normalized <= (mag_r > 33'd8388608) ? -24'sd8388608 : -signed'(mag_r[23:0]);
      end else begin
        normalized <= (mag_r > 33'd8388607) ? 24'sd8388607 : signed'(mag_r[23:0]);
      end
    end
  end

endmodule

### rtl/lnr_ctrl.sv
// controller: sequences load, statistics and output passes
module lnr_ctrl (
  input  logic          clk,
  input  logic          rst,
  input  logic          start,
  input  lnr_pkg::sts_t sts,
  output lnr_pkg::cmd_t cmd,
  output logic          busy
);

  lnr_pkg::state_t           state, state_next;
  logic [lnr_pkg::CNT_W-1:0] idx, idx_next;
  logic                      last;

  // state and index registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= lnr_pkg::S_IDLE;
      idx   <= '0;
    end else begin
      state <= state_next;
      idx   <= idx_next;
    end
  end

  assign last = idx == (sts.n - 1'b1);
  assign busy = state != lnr_pkg::S_IDLE;

  // next state and commands
  always_comb begin
    state_next   = state;
    idx_next     = '0;
    cmd          = '0;
    cmd.div_sel  = lnr_pkg::SEL_MEAN;
    cmd.rd_idx   = idx;
    cmd.rd_last  = last;
    case (state)
      lnr_pkg::S_IDLE: begin
        cmd.load = start;
        if (start && sts.row_full) begin
          state_next = lnr_pkg::S_MEAN_GO;
        end
      end
      lnr_pkg::S_MEAN_GO: begin
        cmd.div_go  = 1'b1;
        cmd.acc_clr = 1'b1;
        state_next  = lnr_pkg::S_MEAN_WAIT;
      end
      lnr_pkg::S_MEAN_WAIT: begin
        if (sts.div_done) begin
          state_next = lnr_pkg::S_VAR_RD;
        end
      end
      lnr_pkg::S_VAR_RD: begin
        cmd.rd_en = 1'b1;
        if (last) begin
          state_next = lnr_pkg::S_VAR_DRAIN;
        end else begin
          idx_next = idx + 1'b1;
        end
      end
      lnr_pkg::S_VAR_DRAIN: begin
        if (!sts.pipe_busy) begin
          state_next = lnr_pkg::S_VDIV_GO;
        end
      end
      lnr_pkg::S_VDIV_GO: begin
        cmd.div_sel = lnr_pkg::SEL_VAR;
        cmd.div_go  = 1'b1;
        state_next  = lnr_pkg::S_VDIV_WAIT;
      end
      lnr_pkg::S_VDIV_WAIT: begin
        cmd.div_sel = lnr_pkg::SEL_VAR;
        if (sts.div_done) begin
          state_next = lnr_pkg::S_RCP_GO;
        end
      end
      lnr_pkg::S_RCP_GO: begin
        cmd.div_sel = lnr_pkg::SEL_RCP;
        cmd.div_go  = 1'b1;
        state_next  = lnr_pkg::S_RCP_WAIT;
      end
      lnr_pkg::S_RCP_WAIT: begin
        cmd.div_sel = lnr_pkg::SEL_RCP;
        if (sts.div_done) begin
          state_next = lnr_pkg::S_SQRT_GO;
        end
      end
      lnr_pkg::S_SQRT_GO: begin
        cmd.sqrt_go = 1'b1;
        state_next  = lnr_pkg::S_SQRT_WAIT;
      end
      lnr_pkg::S_SQRT_WAIT: begin
        if (sts.sqrt_done) begin
          state_next = lnr_pkg::S_OUT_RD;
        end
      end
      lnr_pkg::S_OUT_RD: begin
        cmd.rd_en    = 1'b1;
        cmd.out_pass = 1'b1;
        if (last) begin
          state_next = lnr_pkg::S_OUT_DRAIN;
        end else begin
          idx_next = idx + 1'b1;
        end
      end
      lnr_pkg::S_OUT_DRAIN: begin
        cmd.out_pass = 1'b1;
        if (!sts.pipe_busy) begin
          cmd.row_clr = 1'b1;
          state_next  = lnr_pkg::S_IDLE;
        end
      end
      default: begin
        state_next = lnr_pkg::S_IDLE;
      end
    endcase
  end

endmodule

### rtl/layer_norm_row_unit.sv
// layer norm row unit: top level joining controller and datapath
//
//  channel   ports                          handshake
//  ------    -----------------------------  ------------------------------
//  input     sample                         start high while busy low
//  result    normalized, row_end            strobe high for one cycle
//  config    wr_index, wr_data              wr_en, taken at once
//
// a sample that does not complete a row is stored and the unit stays
// idle. a completing sample starts a row pass: mean divide, variance
// read pass, variance divide, reciprocal divide on the shared bit-serial
// divider, square root, then one word per cycle on the output pass, all
// gated by the row store port. busy stays high for the whole pass; reset
// is synchronous and clears the fill level, sum and controller; results
// cannot be held off.
module layer_norm_row_unit #(
  parameter int MAX_ROW = 64
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  output logic               busy,
  input  logic signed [15:0] sample,
  input  logic               wr_en,
  input  logic [1:0]         wr_index,
  input  logic [15:0]        wr_data,
  output logic signed [23:0] normalized,
  output logic               row_end,
  output logic               strobe
);

  localparam int AW = (MAX_ROW > 1) ? $clog2(MAX_ROW) : 1;

  lnr_pkg::cmd_t cmd;
  lnr_pkg::sts_t sts;

  // sequencing
  lnr_ctrl u_ctrl (
    .clk   (clk),
    .rst   (rst),
    .start (start),
    .sts   (sts),
    .cmd   (cmd),
    .busy  (busy)
  );

  // arithmetic and storage
  lnr_dp #(.MAX_ROW(MAX_ROW), .AW(AW)) u_dp (
    .clk        (clk),
    .rst        (rst),
    .wr_en      (wr_en),
    .wr_index   (wr_index),
    .wr_data    (wr_data),
    .sample     (sample),
    .cmd        (cmd),
    .sts        (sts),
    .normalized (normalized),
    .row_end    (row_end),
    .strobe     (strobe)
  );

  // results only appear during a row pass
  a_strobe_busy: assert property (@(posedge clk) disable iff (rst)
    strobe |-> busy)
    else $error("result word outside a row pass");

  // row end marks a real result word
  a_end_strobe: assert property (@(posedge clk) disable iff (rst)
    row_end |-> strobe)
    else $error("row end without result word");

  // a row pass ends right after its last word
  a_pass_end: assert property (@(posedge clk) disable iff (rst)
    (!$past(rst) && $fell(busy)) |-> $past(row_end))
    else $error("row pass ended without final word");

endmodule
